[rtl/lpw_pkg.sv]
package lpw_pkg;

    // Coordinate width of the endpoints and of the walker position.
    localparam int COORD_BITS = 16;

    // Width and height registers of the frame buffer.
    localparam int DIM_BITS = 13;
    localparam int ADDR_BITS = 24;
    localparam int COLOR_BITS = 32;

    // The major error term grows by at most one delta per pixel over at most
    // 2^COORD_BITS pixels, so it stays below 2^(2*COORD_BITS) in magnitude.
    localparam int ERR_BITS = 2 * COORD_BITS + 2;

    // Width that holds both a sign-extended coordinate and a frame dimension.
    localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    typedef enum logic
    {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } req_kind_t;

    typedef enum logic
    {
        REG_IMAGE_WIDTH = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        req_kind_t                     req_type;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic [COLOR_BITS-1:0]         color_rgba;
    } req_t;

    typedef struct packed
    {
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  write_enable;
        logic                  last_pixel;
    } pix_t;

    // Current walker position handed from the stepper to the output stage.
    typedef struct packed
    {
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic [COLOR_BITS-1:0]        color;
        logic                         last;
    } pix_info_t;

endpackage

[rtl/lpw_stepper.sv]
module lpw_stepper
    import lpw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_fire,
    input  logic      step_fire,
    input  req_t      req,
    output logic      line_active,
    output pix_info_t info
);

    logic                         active_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_y_reg;
    logic [COORD_BITS-1:0]        delta_x_reg;
    logic [COORD_BITS-1:0]        delta_y_reg;
    logic                         dir_x_neg_reg;
    logic                         dir_y_neg_reg;
    logic signed [ERR_BITS-1:0]   error_x_reg;
    logic signed [ERR_BITS-1:0]   error_y_reg;
    logic [COORD_BITS-1:0]        steps_left_reg;
    logic [COLOR_BITS-1:0]        color_reg;

    logic signed [COORD_BITS:0]   dx_full;
    logic signed [COORD_BITS:0]   dy_full;
    logic [COORD_BITS-1:0]        load_dx;
    logic [COORD_BITS-1:0]        load_dy;

    logic signed [ERR_BITS-1:0]   ex_sum;
    logic signed [ERR_BITS-1:0]   ey_sum;
    logic signed [ERR_BITS:0]     ex_dbl;
    logic signed [ERR_BITS:0]     ey_dbl;
    logic signed [ERR_BITS:0]     dx_cmp;
    logic signed [ERR_BITS:0]     dy_cmp;
    logic                         adv_x;
    logic                         adv_y;
    logic signed [COORD_BITS-1:0] cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_next;
    logic signed [ERR_BITS-1:0]   error_x_next;
    logic signed [ERR_BITS-1:0]   error_y_next;
    logic                         last;

    // Endpoint deltas and directions for a new line.
    always_comb
    begin
        dx_full = {req.end_x[COORD_BITS-1], req.end_x} - {req.start_x[COORD_BITS-1], req.start_x};
        dy_full = {req.end_y[COORD_BITS-1], req.end_y} - {req.start_y[COORD_BITS-1], req.start_y};
        load_dx = dx_full[COORD_BITS] ? COORD_BITS'(-dx_full) : dx_full[COORD_BITS-1:0];
        load_dy = dy_full[COORD_BITS] ? COORD_BITS'(-dy_full) : dy_full[COORD_BITS-1:0];
    end

    // One pixel step: accumulate both errors and advance each axis on its test.
    always_comb
    begin
        ex_sum = error_x_reg + $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_x_reg});
        ey_sum = error_y_reg + $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_y_reg});
        ex_dbl = {ex_sum, 1'b0};
        ey_dbl = {ey_sum, 1'b0};
        dx_cmp = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, delta_x_reg});
        dy_cmp = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, delta_y_reg});
        adv_y = ey_dbl > dx_cmp;
        adv_x = ex_dbl > dy_cmp;

        cur_x_next = cur_x_reg;
        error_x_next = ex_sum;
        if (adv_x)
        begin
            cur_x_next = dir_x_neg_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
            error_x_next = ex_sum - $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_y_reg});
        end

        cur_y_next = cur_y_reg;
        error_y_next = ey_sum;
        if (adv_y)
        begin
            cur_y_next = dir_y_neg_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
            error_y_next = ey_sum - $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_x_reg});
        end

        last = (steps_left_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (load_fire)
        begin
            active_reg <= 1'b1;
        end
        else if (step_fire && last)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            cur_x_reg <= req.start_x;
            cur_y_reg <= req.start_y;
            delta_x_reg <= load_dx;
            delta_y_reg <= load_dy;
            dir_x_neg_reg <= req.start_x > req.end_x;
            dir_y_neg_reg <= req.start_y > req.end_y;
            error_x_reg <= '0;
            error_y_reg <= '0;
            steps_left_reg <= (load_dx > load_dy) ? load_dx : load_dy;
            color_reg <= req.color_rgba;
        end
        else if (step_fire && !last)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            error_x_reg <= error_x_next;
            error_y_reg <= error_y_next;
            steps_left_reg <= steps_left_reg - COORD_BITS'(1);
        end
    end

    assign line_active = active_reg;
    assign info.cur_x = cur_x_reg;
    assign info.cur_y = cur_y_reg;
    assign info.color = color_reg;
    assign info.last = last;

endmodule

[rtl/lpw_pixel_out.sv]
module lpw_pixel_out
    import lpw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_fire,
    input  pix_info_t           info,
    input  logic [DIM_BITS-1:0] image_width,
    input  logic [DIM_BITS-1:0] image_height,
    input  logic                pix_ready,
    output logic                pix_valid,
    output pix_t                pix,
    output logic                room
);

    logic                  valid_reg;
    pix_t                  pix_reg;
    logic [CMP_BITS-1:0]   x_c;
    logic [CMP_BITS-1:0]   y_c;
    logic                  in_frame;
    logic [2*DIM_BITS-1:0] row_base;
    logic [ADDR_BITS-1:0]  addr;
    pix_t                  pix_next;

    always_comb
    begin
        x_c = {{(CMP_BITS-COORD_BITS){info.cur_x[COORD_BITS-1]}}, info.cur_x};
        y_c = {{(CMP_BITS-COORD_BITS){info.cur_y[COORD_BITS-1]}}, info.cur_y};
        in_frame = !x_c[CMP_BITS-1] && !y_c[CMP_BITS-1]
                   && (x_c < CMP_BITS'(image_width)) && (y_c < CMP_BITS'(image_height));
        // Inside the frame both coordinates are below 2^DIM_BITS.
        row_base = y_c[DIM_BITS-1:0] * image_width;
        addr = ADDR_BITS'(row_base) + ADDR_BITS'(x_c[DIM_BITS-1:0]);

        pix_next.pixel_address = in_frame ? addr : '0;
        pix_next.pixel_color = info.color;
        pix_next.write_enable = in_frame;
        pix_next.last_pixel = info.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (pix_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            pix_reg <= pix_next;
        end
    end

    assign room = !valid_reg || pix_ready;
    assign pix_valid = valid_reg;
    assign pix = pix_reg;

endmodule

[rtl/line_pixel_walker_core.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_t: load a line or step one pixel
// pix      out        pix_valid / pix_ready  pix_t: address, color, enable, last
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data: frame size
//
// A step transfer writes its pixel into the output register on the edge that
// accepts it, so one pixel leaves per clock while pix_ready stays high.
// The rate is set by the single output register and the step logic feeding it.
// Reset clears the line-active flag and the output valid; the frame size returns
// to 640 by 480. When the output register is full and not drained, req_ready
// drops and the walker holds its position until the pixel is taken.
module line_pixel_walker_core
    import lpw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_t                req,
    output logic                pix_valid,
    input  logic                pix_ready,
    output pix_t                pix,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_reg_t            cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data
);

    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic                req_fire;
    logic                load_fire;
    logic                step_fire;
    logic                line_active;
    logic                room;
    pix_info_t           info;

    // A step transfer with no line armed is consumed and gives no pixel.
    assign req_fire = req_valid && req_ready;
    assign load_fire = req_fire && (req.req_type == REQ_LOAD);
    assign step_fire = req_fire && (req.req_type == REQ_STEP) && line_active;
    assign req_ready = room;
    assign cfg_ready = 1'b1;

    // Frame size; write only while the walker is idle, not enforced by the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Position, error terms and remaining pixel count of the active line.
    lpw_stepper u_stepper
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_fire   (load_fire),
        .step_fire   (step_fire),
        .req         (req),
        .line_active (line_active),
        .info        (info)
    );

    // Bounds check, frame buffer address and the output register.
    lpw_pixel_out u_pixel_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_fire    (step_fire),
        .info         (info),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pix_ready    (pix_ready),
        .pix_valid    (pix_valid),
        .pix          (pix),
        .room         (room)
    );

`ifndef SYNTHESIS
    // Every accepted step on an active line leaves a pixel in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) step_fire |=> pix_valid)
        else $error("step transfer produced no pixel");

    // The final pixel of a line disarms the walker.
    assert property (@(posedge clk) disable iff (!rst_n) (step_fire && info.last) |=> !line_active)
        else $error("line still active after its final pixel");

    // A pixel outside the frame carries a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix.write_enable) |-> (pix.pixel_address == '0))
        else $error("out-of-bounds pixel with nonzero address");
`endif

endmodule

[test/line_pixel_walker_core_tb.sv]
`timescale 1ns / 100ps

module line_pixel_walker_core_tb
    import lpw_pkg::*;
;

    // Error terms saturate here; above any delta the step decision is fixed.
    localparam longint ERR_LIMIT = longint'(1) << 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_t                req = '0;
    logic                pix_valid;
    logic                pix_ready = 1'b0;
    pix_t                pix;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_reg_t            cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_BITS-1:0] cfg_data = '0;

    // Pixels that the walker owes us, oldest first.
    pix_t pixel_queue[$];
    int   fail_count = 0;
    int   items_used = 0;

    // One in N chance of an idle burst on the request side or a stall on the
    // pixel side; zero turns the idling off.
    int gap_odds = 4;
    int stall_odds = 4;
    int stall_left = 0;

    // Shadow copy of the walker state and the frame size registers.
    bit          walk_on = 1'b0;
    longint      pos_x = 0;
    longint      pos_y = 0;
    longint      span_x = 0;
    longint      span_y = 0;
    bit          neg_x = 1'b0;
    bit          neg_y = 1'b0;
    longint      acc_x = 0;
    longint      acc_y = 0;
    longint      pixels_left = 0;
    logic [31:0] walk_color = '0;
    longint      frame_w = 640;
    longint      frame_h = 480;

    line_pixel_walker_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint clip_error(input longint value);
        return (value > ERR_LIMIT) ? ERR_LIMIT : value;
    endfunction

    // Clamp a coordinate into the signed range of the endpoint fields.
    function automatic logic signed [COORD_BITS-1:0] to_coord(input longint value);
        longint hi;
        hi = (longint'(1) << (COORD_BITS - 1)) - 1;
        if (value > hi)
            value = hi;
        else if (value < -hi - 1)
            value = -hi - 1;
        return COORD_BITS'(value);
    endfunction

    function automatic req_t random_request(input req_kind_t kind);
        req_t item;
        item.req_type = kind;
        item.start_x = COORD_BITS'($urandom());
        item.start_y = COORD_BITS'($urandom());
        item.end_x = COORD_BITS'($urandom());
        item.end_y = COORD_BITS'($urandom());
        item.color_rgba = $urandom();
        return item;
    endfunction

    function automatic req_t line_request(input longint sx, input longint sy,
                                          input longint ex, input longint ey,
                                          input logic [31:0] color);
        req_t item;
        item.req_type = REQ_LOAD;
        item.start_x = to_coord(sx);
        item.start_y = to_coord(sy);
        item.end_x = to_coord(ex);
        item.end_y = to_coord(ey);
        item.color_rgba = color;
        return item;
    endfunction

    // Advance the shadow walker by one accepted request and queue the pixel
    // that it produces, if any. A load only arms the line; a step with no
    // line armed is dropped by the block.
    task automatic predict_pixel(input req_t item);
        pix_t   want;
        logic   in_frame;
        longint sx;
        longint sy;
        longint ex;
        longint ey;
        if (item.req_type == REQ_LOAD)
        begin
            sx = $signed(item.start_x);
            sy = $signed(item.start_y);
            ex = $signed(item.end_x);
            ey = $signed(item.end_y);
            span_x = (ex >= sx) ? ex - sx : sx - ex;
            span_y = (ey >= sy) ? ey - sy : sy - ey;
            neg_x = sx > ex;
            neg_y = sy > ey;
            pos_x = sx;
            pos_y = sy;
            acc_x = 0;
            acc_y = 0;
            pixels_left = (span_x > span_y) ? span_x : span_y;
            walk_color = item.color_rgba;
            walk_on = 1'b1;
            items_used++;
        end
        else if (walk_on)
        begin
            in_frame = pos_x >= 0 && pos_y >= 0 && pos_x < frame_w && pos_y < frame_h;
            want.pixel_address = in_frame ? ADDR_BITS'(pos_y * frame_w + pos_x) : '0;
            want.pixel_color = walk_color;
            want.write_enable = in_frame;
            want.last_pixel = (pixels_left == 0);
            pixel_queue.insert(pixel_queue.size(), want);
            items_used++;
            if (pixels_left == 0)
            begin
                walk_on = 1'b0;
            end
            else
            begin
                // Both error terms grow first; each axis then moves by its sign
                // once twice its error passes the other axis delta.
                acc_y = clip_error(acc_y + span_y);
                acc_x = clip_error(acc_x + span_x);
                if (2 * acc_y > span_x)
                begin
                    pos_y += neg_y ? -1 : 1;
                    acc_y -= span_x;
                end
                if (2 * acc_x > span_y)
                begin
                    pos_x += neg_x ? -1 : 1;
                    acc_x -= span_y;
                end
                pixels_left--;
            end
        end
    endtask

    // Present one request and hold it until the transfer completes. Valid is
    // left high so that the next request can follow back to back.
    task automatic send_request(input req_t item);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predict_pixel(item);
    endtask

    // Stop requesting, let every owed pixel drain, then give the output
    // register a few more cycles in case a dropped step is still in flight.
    task automatic settle_walker();
        req_valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Valid stays high after the transfer so that writes can follow back to
    // back; the caller drops it after the last one.
    task automatic write_frame_reg(input cfg_reg_t idx, input logic [DIM_BITS-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH)
            frame_w = value;
        else
            frame_h = value;
    endtask

    task automatic set_frame(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
        settle_walker();
        write_frame_reg(REG_IMAGE_WIDTH, w);
        write_frame_reg(REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // A load followed by a run of steps. Most lines are short and start near
    // the frame so that edges, bounds and the last pixel are hit often; a few
    // run anywhere in the coordinate space and are cut short by the next load.
    task automatic walk_random_segment();
        req_t   item;
        longint sx;
        longint sy;
        longint ex;
        longint ey;
        longint dx;
        longint dy;
        longint span;
        int     len;
        int     n_steps;
        sx = longint'($urandom_range(0, frame_w + 8)) - 4;
        sy = longint'($urandom_range(0, frame_h + 8)) - 4;
        ex = sx + int'($urandom_range(0, 48)) - 24;
        ey = sy + int'($urandom_range(0, 48)) - 24;
        case ($urandom_range(0, 9))
            6, 7:
            begin
                sx = $signed(COORD_BITS'($urandom()));
                sy = $signed(COORD_BITS'($urandom()));
                ex = sx + int'($urandom_range(0, 40)) - 20;
                ey = sy + int'($urandom_range(0, 40)) - 20;
            end
            8:
            begin
                len = int'($urandom_range(0, 40)) - 20;
                case ($urandom_range(0, 3))
                    0: begin ex = sx + len; ey = sy; end
                    1: begin ex = sx; ey = sy + len; end
                    2: begin ex = sx + len; ey = sy + len; end
                    default: begin ex = sx + len; ey = sy - len; end
                endcase
            end
            9:
            begin
                sx = $signed(COORD_BITS'($urandom()));
                sy = $signed(COORD_BITS'($urandom()));
                ex = $signed(COORD_BITS'($urandom()));
                ey = $signed(COORD_BITS'($urandom()));
            end
            default: ;
        endcase
        item = line_request(sx, sy, ex, ey, $urandom());
        send_request(item);

        dx = longint'($signed(item.end_x)) - longint'($signed(item.start_x));
        dy = longint'($signed(item.end_y)) - longint'($signed(item.start_y));
        dx = (dx < 0) ? -dx : dx;
        dy = (dy < 0) ? -dy : dy;
        span = (dx > dy) ? dx : dy;
        // Usually finish the line and sometimes poke it after the end; else
        // stop partway and let the next load replace it.
        if (span <= 64 && $urandom_range(0, 4) != 0)
            n_steps = int'(span) + 1 + $urandom_range(0, 2);
        else
            n_steps = $urandom_range(0, (span < 64) ? int'(span) : 64);
        repeat (n_steps) send_request(random_request(REQ_STEP));
    endtask

    task automatic run_random_items(input int count);
        int target;
        target = items_used + count;
        while (items_used < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(random_request(req_kind_t'($urandom_range(0, 1))));
            else
                walk_random_segment();
        end
    endtask

    // Short hand-picked lines at the reset frame size of 640 by 480.
    task automatic test_directed_lines();
        // Nothing is armed yet, so this step must vanish.
        send_request(random_request(REQ_STEP));

        // A single-pixel line is its own last pixel; the extra step is dropped.
        send_request(line_request(0, 0, 0, 0, 32'h0000_0000));
        repeat (2) send_request(random_request(REQ_STEP));

        // Starts above and left of the frame and walks into it.
        send_request(line_request(-1, -1, 1, 0, 32'hFFFF_FFFF));
        repeat (3) send_request(random_request(REQ_STEP));

        // Walks back from just past the bottom right corner, both signs negative.
        send_request(line_request(640, 480, 638, 479, 32'h12AB_34CD));
        repeat (3) send_request(random_request(REQ_STEP));

        // Coordinate extremes; the line is replaced after two pixels.
        send_request(line_request(-32768, 32767, 32767, -32768, 32'h8000_0001));
        repeat (2) send_request(random_request(REQ_STEP));

        send_request(line_request(3, 5, 10, 2, 32'h5A5A_A5A5));
        repeat (8) send_request(random_request(REQ_STEP));
    endtask

    // Frame sizes at the edges of the register range: an empty frame where no
    // pixel may be written, one pixel, and a size whose addresses pass 24 bits.
    task automatic test_frame_extremes();
        set_frame(0, 480);
        run_random_items(50);
        set_frame(640, 0);
        run_random_items(50);
        set_frame(8191, 8191);
        run_random_items(60);
        set_frame(1, 1);
        run_random_items(50);
        set_frame(4096, 4096);
        run_random_items(50);
    endtask

    // Random frame sizes with the idling changing from phase to phase,
    // including a phase where neither side idles.
    task automatic test_random_walks();
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            if ($urandom_range(0, 4) == 0)
                set_frame(DIM_BITS'($urandom()), DIM_BITS'($urandom()));
            else
                set_frame(DIM_BITS'($urandom_range(1, 700)),
                          DIM_BITS'($urandom_range(1, 500)));
            gap_odds = (phase == 2) ? 0 : $urandom_range(2, 6);
            stall_odds = (phase == 2) ? 0 : $urandom_range(2, 6);
            run_random_items(220);
        end
    endtask

    // Full rate on both sides to close the run.
    task automatic test_back_to_back();
        set_frame(DIM_BITS'($urandom_range(16, 800)), DIM_BITS'($urandom_range(16, 600)));
        gap_odds = 0;
        stall_odds = 0;
        run_random_items(200);
    endtask

    // Pixel side: compare each transfer with the oldest owed pixel, and drive
    // the ready with random stall bursts.
    always @(posedge clk)
    begin
        pix_t want;
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $error("unexpected pixel transfer: address %0h", pix.pixel_address);
                    fail_count++;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (pix.pixel_address !== want.pixel_address)
                    begin
                        $error("pixel_address: expected %0h, got %0h",
                               want.pixel_address, pix.pixel_address);
                        fail_count++;
                    end
                    if (pix.pixel_color !== want.pixel_color)
                    begin
                        $error("pixel_color: expected %0h, got %0h",
                               want.pixel_color, pix.pixel_color);
                        fail_count++;
                    end
                    if (pix.write_enable !== want.write_enable)
                    begin
                        $error("write_enable: expected %0b, got %0b",
                               want.write_enable, pix.write_enable);
                        fail_count++;
                    end
                    if (pix.last_pixel !== want.last_pixel)
                    begin
                        $error("last_pixel: expected %0b, got %0b",
                               want.last_pixel, pix.last_pixel);
                        fail_count++;
                    end
                end
            end

            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                pix_ready <= (stall_left == 1);
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall_left <= $urandom_range(1, 8);
                pix_ready <= 1'b0;
            end
            else
            begin
                pix_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lines();
        test_frame_extremes();
        test_random_walks();
        test_back_to_back();

        settle_walker();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
